### src/ufr_pkg.sv
package ufr_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W = 16;
	localparam int unsigned CNT_W = 11;
	localparam int unsigned POS_W = 10;
	localparam int unsigned LINK_W = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [LEN_W-1:0] MAX_FRAME_LEN = 16'd1024;
	localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hAA;

	localparam logic [BYTE_W-1:0] BYTE_TIMEOUT_RST = 8'd10;
	localparam logic [LINK_W-1:0] LINK_TIMEOUT_RST = 16'd1000;

	localparam logic [CFG_IDX_W-1:0] REG_BYTE_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINK_TIMEOUT = 2'd1;

	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_PAYLOAD = 2'd1,
		EV_GOOD    = 2'd2,
		EV_CSUM    = 2'd3
	} event_t;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_LEN_HI  = 3'd1,
		PH_LEN_LO  = 3'd2,
		PH_CMD     = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CHECK   = 3'd5,
		PH_TRAILER = 3'd6
	} phase_t;

	typedef struct packed {
		logic              mode;
		logic [BYTE_W-1:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] byte_timeout;
		logic [LINK_W-1:0] link_timeout;
	} cfg_t;

	typedef struct packed {
		event_t            event_res;
		logic [BYTE_W-1:0] data;
		logic [POS_W-1:0]  position;
		logic [BYTE_W-1:0] command;
		logic [CNT_W-1:0]  frame_length;
		logic              link_up;
	} res_t;

endpackage

### src/ufr_cfg_regs.sv
module ufr_cfg_regs
	import ufr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	logic [BYTE_W-1:0] byte_timeout_q;
	logic [LINK_W-1:0] link_timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_timeout_q <= BYTE_TIMEOUT_RST;
			link_timeout_q <= LINK_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BYTE_TIMEOUT: byte_timeout_q <= cfg_data[BYTE_W-1:0];
				REG_LINK_TIMEOUT: link_timeout_q <= cfg_data[LINK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.byte_timeout = byte_timeout_q;
	assign cfg.link_timeout = link_timeout_q;

endmodule

### src/ufr_in_reg.sv
module ufr_in_reg
	import ufr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t item_in,
	output logic  valid_s1,
	output item_t item_s1,
	input  logic  take
);

	logic valid_s1_q;

	assign in_ready = !valid_s1_q || take;
	assign valid_s1 = valid_s1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1_q <= 1'b1;
		end else if (take) begin
			valid_s1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_in;
		end
	end

endmodule

### src/ufr_engine.sv
module ufr_engine
	import ufr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  valid_s1,
	input  item_t item_s1,
	output logic  take,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  res
);

	phase_t            phase_q, phase_d;
	logic [LEN_W-1:0]  length_q, length_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [BYTE_W-1:0] sum_q, sum_d;
	logic [BYTE_W-1:0] cmd_q, cmd_d;
	logic [BYTE_W-1:0] btimer_q, btimer_d;
	logic [LINK_W-1:0] ltimer_q, ltimer_d;
	logic [LEN_W-1:0]  len_full;
	logic              out_valid_s2;
	res_t              res_d, res_s2;

	assign take = valid_s1 && (!out_valid_s2 || out_ready);
	assign out_valid = out_valid_s2;
	assign res = res_s2;
	assign len_full = {length_q[BYTE_W-1:0], item_s1.rx_byte};

	always_comb begin
		phase_d = phase_q;
		length_d = length_q;
		count_d = count_q;
		sum_d = sum_q;
		cmd_d = cmd_q;
		btimer_d = btimer_q;
		ltimer_d = ltimer_q;
		res_d.event_res = EV_NONE;
		res_d.data = '0;
		res_d.position = '0;
		if (item_s1.mode == MODE_BYTE) begin
			btimer_d = cfg.byte_timeout;
			unique case (phase_q)
				PH_LEN_HI: begin
					length_d = {{(LEN_W-BYTE_W){1'b0}}, item_s1.rx_byte};
					count_d = '0;
					sum_d = '0;
					phase_d = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					length_d = len_full;
					phase_d = (len_full > MAX_FRAME_LEN) ? PH_HUNT : PH_CMD;
				end
				PH_CMD: begin
					cmd_d = item_s1.rx_byte;
					phase_d = PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					res_d.event_res = EV_PAYLOAD;
					res_d.data = item_s1.rx_byte;
					res_d.position = count_q[POS_W-1:0];
					sum_d = sum_q + item_s1.rx_byte;
					count_d = count_q + 1'b1;
					if (length_q <= {{(LEN_W-CNT_W){1'b0}}, count_d}) begin
						phase_d = PH_CHECK;
					end
				end
				PH_CHECK: begin
					if (item_s1.rx_byte != sum_q) begin
						res_d.event_res = EV_CSUM;
						phase_d = PH_HUNT;
					end else begin
						phase_d = PH_TRAILER;
					end
				end
				PH_TRAILER: begin
					res_d.event_res = EV_GOOD;
					ltimer_d = cfg.link_timeout;
					phase_d = PH_HUNT;
				end
				default: begin
					phase_d = (item_s1.rx_byte == SYNC_BYTE) ? PH_LEN_HI : PH_HUNT;
				end
			endcase
		end else begin
			if (btimer_q != '0) begin
				btimer_d = btimer_q - 1'b1;
				if (btimer_d == '0) begin
					phase_d = PH_HUNT;
				end
			end
			if (ltimer_q != '0) begin
				ltimer_d = ltimer_q - 1'b1;
			end
		end
		res_d.command = cmd_d;
		res_d.frame_length = length_d[CNT_W-1:0];
		res_d.link_up = (ltimer_d != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			length_q <= '0;
			count_q <= '0;
			sum_q <= '0;
			cmd_q <= '0;
			btimer_q <= '0;
			ltimer_q <= '0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_d;
				length_q <= length_d;
				count_q <= count_d;
				sum_q <= sum_d;
				cmd_q <= cmd_d;
				btimer_q <= btimer_d;
				ltimer_q <= ltimer_d;
				out_valid_s2 <= 1'b1;
			end else if (out_ready) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_s2 <= res_d;
		end
	end

endmodule

### src/uart_frame_receiver_core.sv
// Frame receiver for a sync/length/command/payload/checksum/trailer byte stream, with
// inter-byte and link timers driven by tick items. One item (byte or tick) is accepted
// every cycle unless a held result is not read (out_ready back-pressure stalls the input),
// and each gives exactly one result. An accepted item waits in the input register until
// the engine takes it; its state update is combinational and loads with the result register.
// Configuration writes take effect at once and are meant for when the block is idle.
module uart_frame_receiver_core
	import ufr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  mode,
	input  logic [BYTE_W-1:0]     rx_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            event_res,
	output logic [BYTE_W-1:0]     data,
	output logic [POS_W-1:0]      position,
	output logic [BYTE_W-1:0]     command,
	output logic [CNT_W-1:0]      frame_length,
	output logic                  link_up
);

	cfg_t  cfg;
	item_t item_in, item_s1;
	logic  valid_s1;
	logic  take;
	res_t  res;

	assign item_in.mode = mode;
	assign item_in.rx_byte = rx_byte;

	ufr_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	ufr_in_reg u_in (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.item_in (item_in),
		.valid_s1(valid_s1),
		.item_s1 (item_s1),
		.take    (take)
	);

	ufr_engine u_eng (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.take     (take),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.res      (res)
	);

	assign event_res = res.event_res;
	assign data = res.data;
	assign position = res.position;
	assign command = res.command;
	assign frame_length = res.frame_length;
	assign link_up = res.link_up;

	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1)
		else $error("input stalled with empty input register");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid && !out_ready |=> valid_s1 && !$past(take))
		else $error("item advanced while result stalled");

	a_position_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_PAYLOAD |->
			({1'b0, position} < frame_length) || (position == '0))
		else $error("payload position beyond frame length");

endmodule
